// ===== rtl/core/nns_pkg.sv =====
package nns_pkg;

    localparam int REG_DIM_W   = 9;
    localparam int OUT_COORD_W = 8;
    localparam int OUT_DIM_W   = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int COLOR_W     = 8;
    localparam int WORD_W      = 32;
    localparam int BIT_SEL_W   = 5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SRC_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SRC_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_REQ_WIDTH  = 3'd2;
    localparam t_cfg_idx CFG_REQ_HEIGHT = 3'd3;
    localparam t_cfg_idx CFG_PRESERVE   = 3'd4;
    localparam t_cfg_idx CFG_BITMAP     = 3'd5;
    localparam t_cfg_idx CFG_FG_COLOR   = 3'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd128;

    typedef enum logic [1:0] {
        DIV_RATIO  = 2'd0,
        DIV_NH     = 2'd1,
        DIV_STEP_X = 2'd2,
        DIV_STEP_Y = 2'd3
    } t_div_op;

    typedef struct packed {
        logic    start_image;
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    mul_t;
        logic    mul_nw;
        logic    read;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic cfg_hit;
        logic preserve;
        logic last_pix;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/icon_nearest_neighbor_scaler.sv =====
// Nearest-neighbor icon scaler.
// Input channel (i_in_valid / o_in_ready): each word is a command. A load word
// writes i_src_word into the source store at the load pointer and produces no
// result; ready stays high after it. An emit word produces the next pixel of the
// scaled image on the output channel (o_out_valid / i_out_ready), in raster
// order, with o_last on the final pixel; the next loads then start a new image.
// Configuration registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data, one per cycle, by the user only while idle; the block does not enforce it.
// An emit word is taken in idle, the store is read in the read state and the
// output register loaded in the output state; only then is the next word taken.
// The first emit of an image also sizes the output with a radix-2 divider of
// W = clog2(MAX_DIM+1) + FRAC_BITS bits (25 by default): two divisions plain,
// four with aspect fitting.
// Reset (synchronous, active low) restores the register defaults, clears the
// load pointer and the output valid flag; the store keeps old contents.
// When the receiver stalls, the finished pixel waits in the output register;
// one more word may be taken, and a following emit waits for that slot.
module icon_nearest_neighbor_scaler #(
    parameter int MAX_DIM     = 256,
    parameter int STORE_DEPTH = 4096,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nns_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [nns_pkg::WORD_W-1:0]          i_src_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [nns_pkg::OUT_COORD_W-1:0]     o_out_x,
    output logic [nns_pkg::OUT_COORD_W-1:0]     o_out_y,
    output logic [nns_pkg::COLOR_W-1:0]         o_red,
    output logic [nns_pkg::COLOR_W-1:0]         o_green,
    output logic [nns_pkg::COLOR_W-1:0]         o_blue,
    output logic                                o_opaque,
    output logic [nns_pkg::OUT_DIM_W-1:0]       o_out_width,
    output logic [nns_pkg::OUT_DIM_W-1:0]       o_out_height,
    output logic                                o_last
);

    nns_pkg::t_dp_cmd    dp_cmd;
    nns_pkg::t_dp_status dp_status;

    nns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    nns_datapath #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (nns_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data   (i_cfg_data),
        .i_src_word   (i_src_word),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_opaque     (o_opaque),
        .o_out_width  (o_out_width),
        .o_out_height (o_out_height),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/core/nns_div.sv =====
module nns_div #(
    parameter int W = 25
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_quo,
    output logic         o_done
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  n_rem;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? diff[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== rtl/core/nns_datapath.sv =====
module nns_datapath #(
    parameter int MAX_DIM     = 256,
    parameter int STORE_DEPTH = 4096,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  nns_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [nns_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [nns_pkg::WORD_W-1:0]          i_src_word,
    input  nns_pkg::t_dp_cmd                    i_cmd,
    output nns_pkg::t_dp_status                 o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [nns_pkg::OUT_COORD_W-1:0]     o_out_x,
    output logic [nns_pkg::OUT_COORD_W-1:0]     o_out_y,
    output logic [nns_pkg::COLOR_W-1:0]         o_red,
    output logic [nns_pkg::COLOR_W-1:0]         o_green,
    output logic [nns_pkg::COLOR_W-1:0]         o_blue,
    output logic                                o_opaque,
    output logic [nns_pkg::OUT_DIM_W-1:0]       o_out_width,
    output logic [nns_pkg::OUT_DIM_W-1:0]       o_out_height,
    output logic                                o_last
);

    localparam int RW   = nns_pkg::REG_DIM_W;
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int CNTW = $clog2(MAX_DIM);
    localparam int FW   = DW + FRAC_BITS;
    localparam int MW   = DW + FW;
    localparam int CMPW = (DW > RW) ? DW : RW;
    localparam int PXW  = (2 * DW > nns_pkg::BIT_SEL_W) ? 2 * DW : nns_pkg::BIT_SEL_W;
    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int PTRW = $clog2(STORE_DEPTH + 1);
    localparam int ADW  = (PXW > AW + 1) ? PXW : AW + 1;
    localparam int CW   = nns_pkg::COLOR_W;

    // configuration registers
    logic [RW-1:0]                     r_src_w;
    logic [RW-1:0]                     r_src_h;
    logic [RW-1:0]                     r_req_w;
    logic [RW-1:0]                     r_req_h;
    logic                              r_preserve;
    logic                              r_bitmap;
    logic [nns_pkg::CFG_DATA_W-1:0]    r_fg;

    logic [PTRW-1:0]                   r_ptr;
    logic [nns_pkg::WORD_W-1:0]        mem [STORE_DEPTH];

    logic [DW-1:0]                     r_nw;
    logic [DW-1:0]                     r_nh;
    logic [FW-1:0]                     r_ratio;
    logic [FW-1:0]                     r_step_x;
    logic [FW-1:0]                     r_step_y;
    logic [FW-1:0]                     r_xacc;
    logic [FW-1:0]                     r_yacc;
    logic [CNTW-1:0]                   r_col;
    logic [CNTW-1:0]                   r_row;
    logic [PXW-1:0]                    r_row_base;

    logic [nns_pkg::WORD_W-1:0]        r_rdata;
    logic                              r_in_range;
    logic [nns_pkg::BIT_SEL_W-1:0]     r_bitsel;

    logic                              r_out_valid;
    logic [nns_pkg::OUT_COORD_W-1:0]   r_out_x;
    logic [nns_pkg::OUT_COORD_W-1:0]   r_out_y;
    logic [CW-1:0]                     r_red;
    logic [CW-1:0]                     r_green;
    logic [CW-1:0]                     r_blue;
    logic                              r_opaque;
    logic [nns_pkg::OUT_DIM_W-1:0]     r_out_w;
    logic [nns_pkg::OUT_DIM_W-1:0]     r_out_h;
    logic                              r_last;

    logic [DW-1:0]                     sw;
    logic [DW-1:0]                     sh;
    logic [DW-1:0]                     rw;
    logic [DW-1:0]                     rh;
    logic [FW-1:0]                     div_num;
    logic [FW-1:0]                     div_den;
    logic [FW-1:0]                     div_quo;
    logic                              div_done;
    logic [DW-1:0]                     mul_a;
    logic [MW-1:0]                     mul_p;
    logic [PXW-1:0]                    t_full;
    logic [DW-1:0]                     nw_fit;
    logic [DW-1:0]                     xi;
    logic [DW-1:0]                     yi;
    logic [PXW-1:0]                    pix;
    logic [PXW-1:0]                    word_addr;
    logic [ADW-1:0]                    addr_ext;
    logic                              in_range;
    logic                              col_end;
    logic                              row_end;
    logic [nns_pkg::WORD_W-1:0]        word;
    logic                              bit_set;

    function automatic logic [DW-1:0] clamp_dim(input logic [RW-1:0] v,
                                                input logic [DW-1:0] dflt);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = dflt;
        end else if (CMPW'(v) > CMPW'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    always_comb begin
        sw = clamp_dim(r_src_w, DW'(1));
        sh = clamp_dim(r_src_h, DW'(1));
        rw = clamp_dim(r_req_w, sw);
        rh = clamp_dim(r_req_h, sh);
    end

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= RW'(1);
            r_src_h    <= RW'(1);
            r_req_w    <= '0;
            r_req_h    <= '0;
            r_preserve <= 1'b1;
            r_bitmap   <= 1'b0;
            r_fg       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nns_pkg::CFG_SRC_WIDTH:  r_src_w    <= i_cfg_data[RW-1:0];
                nns_pkg::CFG_SRC_HEIGHT: r_src_h    <= i_cfg_data[RW-1:0];
                nns_pkg::CFG_REQ_WIDTH:  r_req_w    <= i_cfg_data[RW-1:0];
                nns_pkg::CFG_REQ_HEIGHT: r_req_h    <= i_cfg_data[RW-1:0];
                nns_pkg::CFG_PRESERVE:   r_preserve <= i_cfg_data[0];
                nns_pkg::CFG_BITMAP:     r_bitmap   <= i_cfg_data[0];
                nns_pkg::CFG_FG_COLOR:   r_fg       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared divider for the ratio, the fitted height and both steps
    always_comb begin
        case (i_cmd.div_op)
            nns_pkg::DIV_RATIO: begin
                div_num = {sw, {FRAC_BITS{1'b0}}};
                div_den = FW'(sh);
            end
            nns_pkg::DIV_NH: begin
                div_num = {r_nw, {FRAC_BITS{1'b0}}};
                div_den = r_ratio;
            end
            nns_pkg::DIV_STEP_X: begin
                div_num = {sw, {FRAC_BITS{1'b0}}};
                div_den = FW'(r_nw);
            end
            default: begin
                div_num = {sh, {FRAC_BITS{1'b0}}};
                div_den = FW'(r_nh);
            end
        endcase
    end

    nns_div #(
        .W (FW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // aspect fit multiplier
    always_comb begin
        mul_a  = i_cmd.mul_nw ? r_nh : rh;
        mul_p  = MW'(mul_a) * MW'(r_ratio);
        t_full = PXW'(mul_p[MW-1:FRAC_BITS]);
        nw_fit = mul_p[FRAC_BITS+DW-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_image) begin
            r_nw <= rw;
            r_nh <= rh;
        end else if (i_cmd.mul_t) begin
            r_nw <= (PXW'(rw) < t_full) ? rw : t_full[DW-1:0];
        end else if (i_cmd.mul_nw) begin
            r_nw <= (nw_fit == '0) ? DW'(1) : nw_fit;
            r_nh <= (r_nh == '0) ? DW'(1) : r_nh;
        end else if (div_done && i_cmd.div_op == nns_pkg::DIV_NH) begin
            r_nh <= (FW'(rh) < div_quo) ? rh : div_quo[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.div_op)
                nns_pkg::DIV_RATIO:  r_ratio  <= (div_quo == '0) ? FW'(1) : div_quo;
                nns_pkg::DIV_STEP_X: r_step_x <= div_quo;
                nns_pkg::DIV_STEP_Y: r_step_y <= div_quo;
                default: ;
            endcase
        end
    end

    // raster walk
    always_comb begin
        xi      = r_xacc[FW-1:FRAC_BITS];
        yi      = r_yacc[FW-1:FRAC_BITS];
        col_end = ((DW'(r_col) + DW'(1)) >= r_nw);
        row_end = ((DW'(r_row) + DW'(1)) >= r_nh);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_image) begin
            r_xacc <= '0;
            r_yacc <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cmd.emit) begin
            if (col_end) begin
                r_col  <= '0;
                r_xacc <= '0;
                if (row_end) begin
                    r_row  <= '0;
                    r_yacc <= '0;
                end else begin
                    r_row  <= r_row + CNTW'(1);
                    r_yacc <= r_yacc + r_step_y;
                end
            end else begin
                r_col  <= r_col + CNTW'(1);
                r_xacc <= r_xacc + r_step_x;
            end
        end
    end

    // row offset tracks the current row
    always_ff @(posedge i_clk) begin
        r_row_base <= PXW'(yi) * PXW'(sw);
    end

    always_comb begin
        pix       = r_row_base + PXW'(xi);
        word_addr = r_bitmap ? (pix >> nns_pkg::BIT_SEL_W) : pix;
        addr_ext  = ADW'(word_addr);
        in_range  = (addr_ext < ADW'(STORE_DEPTH));
    end

    // load pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.emit && col_end && row_end) begin
            r_ptr <= '0;
        end else if (i_cmd.load && r_ptr < PTRW'(STORE_DEPTH)) begin
            r_ptr <= r_ptr + PTRW'(1);
        end
    end

    // source store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_ptr < PTRW'(STORE_DEPTH)) begin
            mem[r_ptr[AW-1:0]] <= i_src_word;
        end
        if (i_cmd.read) begin
            r_rdata    <= mem[addr_ext[AW-1:0]];
            r_in_range <= in_range;
            r_bitsel   <= pix[nns_pkg::BIT_SEL_W-1:0];
        end
    end

    // pixel format
    always_comb begin
        word    = r_in_range ? r_rdata : '0;
        bit_set = word[r_bitsel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x <= nns_pkg::OUT_COORD_W'(r_col);
            r_out_y <= nns_pkg::OUT_COORD_W'(r_row);
            r_out_w <= nns_pkg::OUT_DIM_W'(r_nw);
            r_out_h <= nns_pkg::OUT_DIM_W'(r_nh);
            r_last  <= col_end && row_end;
            if (r_bitmap) begin
                r_red    <= bit_set ? r_fg[23:16] : '0;
                r_green  <= bit_set ? r_fg[15:8]  : '0;
                r_blue   <= bit_set ? r_fg[7:0]   : '0;
                r_opaque <= bit_set;
            end else begin
                r_red    <= word[23:16];
                r_green  <= word[15:8];
                r_blue   <= word[7:0];
                r_opaque <= (word[31:24] >= nns_pkg::ALPHA_OPAQUE);
            end
        end
    end

    always_comb begin
        o_status.div_done = div_done;
        o_status.cfg_hit  = i_cfg_we && (i_cfg_index <= nns_pkg::CFG_FG_COLOR);
        o_status.preserve = r_preserve;
        o_status.last_pix = col_end && row_end;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_opaque     = r_opaque;
    assign o_out_width  = r_out_w;
    assign o_out_height = r_out_h;
    assign o_last       = r_last;

endmodule

// ===== rtl/core/nns_ctrl.sv =====
module nns_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    output logic                o_in_ready,
    input  nns_pkg::t_dp_status i_status,
    output nns_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV_RATIO = 9'b000000010,
        ST_MUL_T     = 9'b000000100,
        ST_DIV_NH    = 9'b000001000,
        ST_MUL_NW    = 9'b000010000,
        ST_DIV_SX    = 9'b000100000,
        ST_DIV_SY    = 9'b001000000,
        ST_READ      = 9'b010000000,
        ST_OUT       = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_active;
    logic   n_active;
    logic   r_div_issued;
    logic   n_div_issued;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_div_issued = r_div_issued;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == nns_pkg::CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_active   = 1'b0;
                    end else if (r_active) begin
                        n_state = ST_READ;
                    end else begin
                        o_cmd.start_image = 1'b1;
                        n_active          = 1'b1;
                        n_state           = i_status.preserve ? ST_DIV_RATIO : ST_DIV_SX;
                    end
                end
            end
            ST_DIV_RATIO: begin
                o_cmd.div_op    = nns_pkg::DIV_RATIO;
                o_cmd.div_start = !r_div_issued;
                n_div_issued    = 1'b1;
                if (i_status.div_done) begin
                    n_div_issued = 1'b0;
                    n_state      = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                o_cmd.mul_t = 1'b1;
                n_state     = ST_DIV_NH;
            end
            ST_DIV_NH: begin
                o_cmd.div_op    = nns_pkg::DIV_NH;
                o_cmd.div_start = !r_div_issued;
                n_div_issued    = 1'b1;
                if (i_status.div_done) begin
                    n_div_issued = 1'b0;
                    n_state      = ST_MUL_NW;
                end
            end
            ST_MUL_NW: begin
                o_cmd.mul_nw = 1'b1;
                n_state      = ST_DIV_SX;
            end
            ST_DIV_SX: begin
                o_cmd.div_op    = nns_pkg::DIV_STEP_X;
                o_cmd.div_start = !r_div_issued;
                n_div_issued    = 1'b1;
                if (i_status.div_done) begin
                    n_div_issued = 1'b0;
                    n_state      = ST_DIV_SY;
                end
            end
            ST_DIV_SY: begin
                o_cmd.div_op    = nns_pkg::DIV_STEP_Y;
                o_cmd.div_start = !r_div_issued;
                n_div_issued    = 1'b1;
                if (i_status.div_done) begin
                    n_div_issued = 1'b0;
                    n_state      = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_active   = !i_status.last_pix;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // a register write drops the image in progress
        if (i_status.cfg_hit) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= 1'b0;
            r_div_issued <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_div_issued <= n_div_issued;
        end
    end

endmodule

// ===== rtl/core/nns_checker.sv =====
module nns_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [nns_pkg::OUT_COORD_W-1:0]     o_out_x,
    input logic [nns_pkg::OUT_COORD_W-1:0]     o_out_y,
    input logic [nns_pkg::COLOR_W-1:0]         o_red,
    input logic [nns_pkg::COLOR_W-1:0]         o_green,
    input logic [nns_pkg::COLOR_W-1:0]         o_blue,
    input logic                                o_opaque,
    input logic [nns_pkg::OUT_DIM_W-1:0]       o_out_width,
    input logic [nns_pkg::OUT_DIM_W-1:0]       o_out_height,
    input logic                                o_last
);

    localparam int DIMW = nns_pkg::OUT_DIM_W;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_x)
            && $stable(o_out_y) && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_opaque) && $stable(o_last))
        else $error("output word changed while stalled");

    a_x_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DIMW'(o_out_x) < o_out_width))
        else $error("column outside output width");

    a_y_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DIMW'(o_out_y) < o_out_height))
        else $error("row outside output height");

    // last marks the bottom right corner only
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (DIMW'(o_out_x) + DIMW'(1) == o_out_width)
            && (DIMW'(o_out_y) + DIMW'(1) == o_out_height))
        else $error("last flag away from final pixel");

endmodule

bind icon_nearest_neighbor_scaler nns_checker u_nns_checker (.*);

// ===== dv/tb_icon_nearest_neighbor_scaler.sv =====
module tb_icon_nearest_neighbor_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC  = 16;
    localparam int DEPTH = 256;
    localparam int DAW   = $clog2(DEPTH);
    localparam int MAXD  = 256;

    localparam nns_pkg::t_cfg_idx CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [nns_pkg::OUT_COORD_W-1:0] out_x;
        logic [nns_pkg::OUT_COORD_W-1:0] out_y;
        logic [nns_pkg::COLOR_W-1:0]     red;
        logic [nns_pkg::COLOR_W-1:0]     green;
        logic [nns_pkg::COLOR_W-1:0]     blue;
        logic                            opaque;
        logic [nns_pkg::OUT_DIM_W-1:0]   out_width;
        logic [nns_pkg::OUT_DIM_W-1:0]   out_height;
        logic                            last;
    } t_scaled_pixel;

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_we     = 1'b0;
    logic [nns_pkg::CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [nns_pkg::CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                            i_in_valid   = 1'b0;
    logic                            o_in_ready;
    logic                            i_command    = nns_pkg::CMD_LOAD;
    logic [nns_pkg::WORD_W-1:0]      i_src_word   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready  = 1'b0;
    logic [nns_pkg::OUT_COORD_W-1:0] o_out_x;
    logic [nns_pkg::OUT_COORD_W-1:0] o_out_y;
    logic [nns_pkg::COLOR_W-1:0]     o_red;
    logic [nns_pkg::COLOR_W-1:0]     o_green;
    logic [nns_pkg::COLOR_W-1:0]     o_blue;
    logic                            o_opaque;
    logic [nns_pkg::OUT_DIM_W-1:0]   o_out_width;
    logic [nns_pkg::OUT_DIM_W-1:0]   o_out_height;
    logic                            o_last;

    icon_nearest_neighbor_scaler #(
        .STORE_DEPTH (DEPTH)
    ) dut (.*);

    // Scaler state as the testbench sees it
    logic [31:0] src_store [DEPTH];
    logic [12:0] load_ptr        = '0;
    logic        emitting        = 1'b0;
    logic [8:0]  dst_w           = 9'd1;
    logic [8:0]  dst_h           = 9'd1;
    logic [24:0] step_x          = '0;
    logic [24:0] step_y          = '0;
    logic [24:0] acc_x           = '0;
    logic [24:0] acc_y           = '0;
    logic [7:0]  col             = '0;
    logic [7:0]  row             = '0;
    logic [8:0]  reg_src_w       = 9'd1;
    logic [8:0]  reg_src_h       = 9'd1;
    logic [8:0]  reg_req_w       = 9'd0;
    logic [8:0]  reg_req_h       = 9'd0;
    logic        reg_keep_aspect = 1'b1;
    logic        reg_bitmap      = 1'b0;
    logic [23:0] reg_fg          = '0;

    t_scaled_pixel pending_pixels [$];

    int error_count    = 0;
    int words_sent     = 0;
    int pixels_checked = 0;
    int images_done    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Timeout: scaler stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [8:0] if_zero);
        if (v == 9'd0) return if_zero;
        if (v > 9'(MAXD)) return 9'(MAXD);
        return v;
    endfunction

    function automatic void fit_size(input logic [8:0] sw_raw, input logic [8:0] sh_raw,
                                     input logic [8:0] rw_raw, input logic [8:0] rh_raw,
                                     input logic keep, output logic [8:0] w,
                                     output logic [8:0] h);
        logic [8:0]  cw, ch, bw, bh;
        logic [40:0] ratio, t, nw, nh;
        cw = clamp_dim(sw_raw, 9'd1);
        ch = clamp_dim(sh_raw, 9'd1);
        bw = clamp_dim(rw_raw, cw);
        bh = clamp_dim(rh_raw, ch);
        if (keep) begin
            ratio = (41'(cw) << FRAC) / 41'(ch);
            if (ratio == 41'd0) ratio = 41'd1;
            t  = (41'(bh) * ratio) >> FRAC;
            nw = (41'(bw) < t) ? 41'(bw) : t;
            t  = (nw << FRAC) / ratio;
            nh = (41'(bh) < t) ? 41'(bh) : t;
            nw = (nh * ratio) >> FRAC;
        end else begin
            nw = 41'(bw);
            nh = 41'(bh);
        end
        if (nw < 41'd1) nw = 41'd1;
        if (nh < 41'd1) nh = 41'd1;
        w = nw[8:0];
        h = nh[8:0];
    endfunction

    function automatic void apply_register(input nns_pkg::t_cfg_idx idx,
                                           input logic [23:0] data);
        if (idx > nns_pkg::CFG_FG_COLOR) return;
        emitting = 1'b0;
        case (idx)
            nns_pkg::CFG_SRC_WIDTH:  reg_src_w       = data[8:0];
            nns_pkg::CFG_SRC_HEIGHT: reg_src_h       = data[8:0];
            nns_pkg::CFG_REQ_WIDTH:  reg_req_w       = data[8:0];
            nns_pkg::CFG_REQ_HEIGHT: reg_req_h       = data[8:0];
            nns_pkg::CFG_PRESERVE:   reg_keep_aspect = data[0];
            nns_pkg::CFG_BITMAP:     reg_bitmap      = data[0];
            default:                 reg_fg          = data[23:0];
        endcase
    endfunction

    function automatic void store_word(input logic [31:0] word);
        emitting = 1'b0;
        // drop loads once the store is full
        if (load_ptr < 13'(DEPTH)) begin
            src_store[load_ptr[DAW-1:0]] = word;
            load_ptr++;
        end
    endfunction

    function automatic t_scaled_pixel predict_emit();
        t_scaled_pixel p;
        logic [8:0]    cw, ch;
        logic [31:0]   pix, word;
        cw = clamp_dim(reg_src_w, 9'd1);
        ch = clamp_dim(reg_src_h, 9'd1);
        if (!emitting) begin
            fit_size(reg_src_w, reg_src_h, reg_req_w, reg_req_h, reg_keep_aspect,
                     dst_w, dst_h);
            step_x   = 25'((41'(cw) << FRAC) / 41'(dst_w));
            step_y   = 25'((41'(ch) << FRAC) / 41'(dst_h));
            acc_x    = '0;
            acc_y    = '0;
            col      = '0;
            row      = '0;
            emitting = 1'b1;
        end
        pix = 32'(acc_y >> FRAC) * 32'(cw) + 32'(acc_x >> FRAC);
        p = '0;
        if (reg_bitmap) begin
            word = ((pix >> 5) < 32'(DEPTH)) ? src_store[DAW'(pix >> 5)] : 32'd0;
            if (word[pix[4:0]]) begin
                p.red    = reg_fg[23:16];
                p.green  = reg_fg[15:8];
                p.blue   = reg_fg[7:0];
                p.opaque = 1'b1;
            end
        end else begin
            // anything beyond the store reads as zero
            word = (pix < 32'(DEPTH)) ? src_store[pix[DAW-1:0]] : 32'd0;
            p.red    = word[23:16];
            p.green  = word[15:8];
            p.blue   = word[7:0];
            p.opaque = (word[31:24] >= nns_pkg::ALPHA_OPAQUE);
        end
        p.out_x      = col;
        p.out_y      = row;
        p.out_width  = dst_w;
        p.out_height = dst_h;
        if ({2'b0, col} + 10'd1 >= {1'b0, dst_w}) begin
            col   = '0;
            acc_x = '0;
            if ({2'b0, row} + 10'd1 >= {1'b0, dst_h}) begin
                p.last   = 1'b1;
                row      = '0;
                acc_y    = '0;
                emitting = 1'b0;
                load_ptr = '0;
            end else begin
                row++;
                acc_y += step_y;
            end
        end else begin
            col++;
            acc_x += step_x;
        end
        return p;
    endfunction

    function automatic string pixel_text(input t_scaled_pixel p);
        return $sformatf("(%0d,%0d) rgb %02h%02h%02h opaque %0b size %0dx%0d last %0b",
                         p.out_x, p.out_y, p.red, p.green, p.blue, p.opaque,
                         p.out_width, p.out_height, p.last);
    endfunction

    function automatic void log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%0t ERROR: %s", $time, msg);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_scaled_pixel seen, want;
        if (i_rst_n) begin
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                if (i_command == nns_pkg::CMD_LOAD) store_word(i_src_word);
                else pending_pixels.push_back(predict_emit());
            end
            if (o_out_valid && i_out_ready) begin
                seen = '{o_out_x, o_out_y, o_red, o_green, o_blue, o_opaque,
                         o_out_width, o_out_height, o_last};
                if (pending_pixels.size() == 0) begin
                    log_error({"unexpected pixel ", pixel_text(seen)});
                end else begin
                    want = pending_pixels.pop_front();
                    if (seen.out_x !== want.out_x || seen.out_y !== want.out_y ||
                        seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue || seen.opaque !== want.opaque ||
                        seen.out_width !== want.out_width ||
                        seen.out_height !== want.out_height || seen.last !== want.last)
                        log_error({"expected ", pixel_text(want), " got ", pixel_text(seen)});
                end
                pixels_checked++;
                if (o_last) images_done++;
            end
        end
    end

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    task automatic send_word(input logic cmd, input logic [31:0] word);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_src_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic hold_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_words(input int n);
        repeat (n) send_word(nns_pkg::CMD_LOAD, $urandom);
    endtask

    task automatic emit_pixels(input int n);
        repeat (n) send_word(nns_pkg::CMD_EMIT, $urandom);
    endtask

    // Wait for every pixel, then let a trailing load finish
    task automatic settle();
        hold_input();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(input nns_pkg::t_cfg_idx idx,
                             input logic [nns_pkg::CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [8:0] sw, input logic [8:0] sh,
                                input logic [8:0] rw, input logic [8:0] rh,
                                input logic keep);
        cfg_write(nns_pkg::CFG_SRC_WIDTH,  {15'($urandom), sw});
        cfg_write(nns_pkg::CFG_SRC_HEIGHT, {15'($urandom), sh});
        cfg_write(nns_pkg::CFG_REQ_WIDTH,  {15'($urandom), rw});
        cfg_write(nns_pkg::CFG_REQ_HEIGHT, {15'($urandom), rh});
        cfg_write(nns_pkg::CFG_PRESERVE,   {23'($urandom), keep});
    endtask

    function automatic logic [8:0] draw_src_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 9'd0;
        if (roll < 10) return 9'($urandom_range(257, 511));
        if (roll < 60) return 9'($urandom_range(1, 16));
        return 9'($urandom_range(1, 256));
    endfunction

    function automatic logic [8:0] draw_req_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 9'd0;
        if (roll < 22) return 9'($urandom_range(257, 511));
        if (roll < 75) return 9'($urandom_range(1, 12));
        return 9'($urandom_range(1, 256));
    endfunction

    // Register defaults give a 1x1 image; check the alpha threshold on both sides
    task automatic test_reset_defaults();
        send_word(nns_pkg::CMD_LOAD, 32'h8012_3456);
        emit_pixels(1);
        send_word(nns_pkg::CMD_LOAD, 32'h7FAB_CDEF);
        emit_pixels(1);
        hold_input();
    endtask

    // Fill every store entry, push past the end, then read beyond the store
    task automatic test_store_overflow();
        cfg_write(nns_pkg::CFG_BITMAP, {23'($urandom), 1'b0});
        set_geometry(9'd256, 9'd256, 9'd2, 9'd2, 1'b0);
        load_words(DEPTH + 3);
        emit_pixels(4);
        hold_input();
    endtask

    task automatic test_abandon();
        set_geometry(9'd4, 9'd1, 9'd0, 9'd0, 1'b0);
        emit_pixels(2);
        // writes to the spare index leave the image running
        cfg_write(CFG_UNUSED, 24'($urandom));
        emit_pixels(2);
        emit_pixels(2);
        load_words(1);
        emit_pixels(4);
        emit_pixels(1);
        cfg_write(nns_pkg::CFG_SRC_WIDTH, 24'd4);
        emit_pixels(4);
        hold_input();
    endtask

    task automatic test_bitmap_source();
        cfg_write(nns_pkg::CFG_BITMAP, {23'($urandom), 1'b1});
        cfg_write(nns_pkg::CFG_FG_COLOR, 24'hFF_FFFF);
        set_geometry(9'd32, 9'd2, 9'd16, 9'd0, 1'b0);
        send_word(nns_pkg::CMD_LOAD, 32'hFFFF_0000);
        send_word(nns_pkg::CMD_LOAD, 32'h0000_FFFF);
        emit_pixels(32);
        cfg_write(nns_pkg::CFG_FG_COLOR, 24'h00_0000);
        emit_pixels(32);
        cfg_write(nns_pkg::CFG_BITMAP, {23'($urandom), 1'b0});
    endtask

    task automatic test_extreme_sizes();
        set_geometry(9'd511, 9'd1, 9'd256, 9'd0, 1'b0);
        emit_pixels(256);
        set_geometry(9'd1, 9'd256, 9'd0, 9'd0, 1'b1);
        emit_pixels(256);
        set_geometry(9'd256, 9'd256, 9'd511, 9'd511, 1'b1);
        emit_pixels(30);
        // aspect fit collapses to zero, so both sides go to one
        set_geometry(9'd1, 9'd256, 9'd5, 9'd100, 1'b1);
        emit_pixels(1);
        set_geometry(9'd0, 9'd0, 9'd0, 9'd0, 1'b1);
        emit_pixels(1);
        set_geometry(9'd200, 9'd50, 9'd64, 9'd64, 1'b1);
        emit_pixels(70);
        load_words(1);
        emit_pixels(3);
        hold_input();
    endtask

    task automatic test_random_images(input int n_words);
        int         start, img, npix, n;
        logic [8:0] w, h;
        start = words_sent;
        img   = 0;
        // rotate the idle pattern per image so every pattern gets a turn
        while (words_sent - start < n_words || img < 4) begin
            settle();
            case (img % 4)
                0:       set_idling(0, 0);
                1:       set_idling(74, 0);
                2:       set_idling(0, 74);
                default: set_idling(11, 11);
            endcase
            img++;
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_SRC_WIDTH, {15'($urandom), draw_src_dim()});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_SRC_HEIGHT, {15'($urandom), draw_src_dim()});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_REQ_WIDTH, {15'($urandom), draw_req_dim()});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_REQ_HEIGHT, {15'($urandom), draw_req_dim()});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_PRESERVE, {23'($urandom), 1'($urandom)});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_BITMAP, {23'($urandom), 1'($urandom)});
            if ($urandom_range(0, 99) < 60)
                cfg_write(nns_pkg::CFG_FG_COLOR, 24'($urandom));
            if ($urandom_range(0, 19) == 0)
                cfg_write(CFG_UNUSED, 24'($urandom));
            fit_size(reg_src_w, reg_src_h, reg_req_w, reg_req_h, reg_keep_aspect, w, h);
            npix = int'(w) * int'(h);
            n = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(13, 64);
            load_words(n);
            // big images, and some small ones, get cut short, to be abandoned by a later write or load
            if (npix <= 400 && $urandom_range(0, 99) < 85) n = npix;
            else n = $urandom_range(1, (npix < 40) ? npix : 40);
            repeat (n) begin
                if ($urandom_range(0, 99) < 3) send_word(nns_pkg::CMD_LOAD, $urandom);
                send_word(nns_pkg::CMD_EMIT, $urandom);
            end
        end
        hold_input();
    endtask

    initial begin : run_tests
        int guard;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idling(0, 0);
        test_reset_defaults();
        set_idling(11, 11);
        test_store_overflow();
        test_abandon();
        test_bitmap_source();
        test_extreme_sizes();
        test_random_images(300);
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            log_error($sformatf("%0d expected pixels never arrived", pending_pixels.size()));
        $display("Sent %0d words, checked %0d pixels, %0d images ran to the end, %0d errors",
                 words_sent, pixels_checked, images_done, error_count);
        $display("Covered ARGB and bitmap sources, aspect fit, clamps, full store, abandons");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/nns_pkg.sv
rtl/core/nns_div.sv
rtl/core/nns_datapath.sv
rtl/core/nns_ctrl.sv
rtl/core/icon_nearest_neighbor_scaler.sv
rtl/core/nns_checker.sv
dv/tb_icon_nearest_neighbor_scaler.sv
